// ===== rtl/core/btst_pkg.sv =====
package btst_pkg;

    // Default sizes for the tracker.
    localparam int CAPACITY_DEF   = 4;
    localparam int ID_BITS_DEF    = 24;
    localparam int SCORE_BITS_DEF = 32;

    // Fixed field widths.
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 4;
    localparam int TOTAL_W  = 3;

    // Operation codes carried by the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_OFFER  = 3'd0,
        FUNC_PEEK   = 3'd1,
        FUNC_POP    = 3'd2,
        FUNC_DELETE = 3'd3,
        FUNC_QUERY  = 3'd4
    } func_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 4'd0,
        STAT_REPLACED  = 4'd1,
        STAT_REJECTED  = 4'd2,
        STAT_DUPLICATE = 4'd3,
        STAT_RETURNED  = 4'd4,
        STAT_EMPTY     = 4'd5,
        STAT_DELETED   = 4'd6,
        STAT_ABSENT    = 4'd7,
        STAT_ANSWERED  = 4'd8
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_APPLY  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

// ===== rtl/core/btst_in_if.sv =====
interface btst_in_if #(
    parameter int ID_W    = btst_pkg::ID_BITS_DEF,
    parameter int SCORE_W = btst_pkg::SCORE_BITS_DEF
);
    import btst_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [ID_W-1:0]           item_id;
    logic signed [SCORE_W-1:0] score;

    modport source (output valid, output func, output item_id, output score, input ready);
    modport sink   (input valid, input func, input item_id, input score, output ready);

endinterface

// ===== rtl/core/btst_out_if.sv =====
interface btst_out_if #(
    parameter int ID_W    = btst_pkg::ID_BITS_DEF,
    parameter int SCORE_W = btst_pkg::SCORE_BITS_DEF
);
    import btst_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [ID_W-1:0]           out_id;
    logic signed [SCORE_W-1:0] out_score;
    logic                      is_top;
    logic [TOTAL_W-1:0]        entry_total;

    modport source (
        output valid, output status, output out_id, output out_score,
        output is_top, output entry_total, input ready
    );
    modport sink (
        input valid, input status, input out_id, input out_score,
        input is_top, input entry_total, output ready
    );

endinterface

// ===== rtl/core/btst_ram.sv =====
module btst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bounded_top_scores_tracker_core.sv =====
// Channel  Direction  Handshake     Payload
// in_ch    input      valid/ready   func, item_id, score
// out_ch   output     valid/ready   status, out_id, out_score, is_top, entry_total
//
// Each transaction is scanned one slot per cycle through a single read port of the
// slot memory, with one shared signed comparator. After an offer that writes a slot,
// the lowest slot is found again by a second scan.
// The input is ready only in the idle state; a held result stalls only the finish step.
// Reset (rst_n, asynchronous) clears all valid bits, the count and the victim slot.
module bounded_top_scores_tracker_core #(
    parameter int CAPACITY   = btst_pkg::CAPACITY_DEF,
    parameter int ID_BITS    = btst_pkg::ID_BITS_DEF,
    parameter int SCORE_BITS = btst_pkg::SCORE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    btst_in_if.sink     in_ch,
    btst_out_if.source  out_ch
);
    import btst_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int SCAN_W = $clog2(CAPACITY + 1);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = ID_BITS + SCORE_BITS;
    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

    // Control registers.
    state_t                   state_reg, state_next;
    logic [SCAN_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                     rd_live_reg, rd_live_next;
    logic                     pass_victim_reg, pass_victim_next;
    logic                     found_reg, found_next;
    logic [CAPACITY-1:0]      valid_reg, valid_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         victim_idx_reg, victim_idx_next;
    logic signed [SCORE_BITS-1:0] victim_score_reg, victim_score_next;
    logic                     out_valid_reg, out_valid_next;

    // Payload registers.
    logic [IDX_W-1:0]         eval_idx_reg, eval_idx_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic                     best_valid_reg, best_valid_next;
    logic signed [SCORE_BITS-1:0] best_score_reg, best_score_next;
    logic [ID_BITS-1:0]       best_id_reg, best_id_next;
    func_t                    op_func_reg, op_func_next;
    logic [ID_BITS-1:0]       op_id_reg, op_id_next;
    logic signed [SCORE_BITS-1:0] op_score_reg, op_score_next;
    status_t                  res_status_reg, res_status_next;
    logic [ID_BITS-1:0]       res_id_reg, res_id_next;
    logic signed [SCORE_BITS-1:0] res_score_reg, res_score_next;
    logic                     res_top_reg, res_top_next;
    status_t                  out_status_reg, out_status_next;
    logic [ID_BITS-1:0]       out_id_reg, out_id_next;
    logic signed [SCORE_BITS-1:0] out_score_reg, out_score_next;
    logic                     out_top_reg, out_top_next;
    logic [TOTAL_W-1:0]       out_total_reg, out_total_next;

    // Slot memory and scan datapath.
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_raddr;
    logic [WORD_W-1:0]        ram_rdata;
    logic signed [SCORE_BITS-1:0] rd_score;
    logic [ID_BITS-1:0]       rd_id;
    logic                     slot_v;
    logic                     scan_more;
    logic signed [SCORE_BITS-1:0] cmp_a, cmp_b;
    logic                     cmp_gt;
    logic                     store_full;
    logic                     out_free;

    btst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (victim_idx_reg),
        .wdata ({op_id_reg, op_score_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scan_more = scan_idx_reg < SCAN_W'(CAPACITY);
    assign ram_raddr = scan_more ? scan_idx_reg[IDX_W-1:0] : '0;
    assign rd_score  = ram_rdata[SCORE_BITS-1:0];
    assign rd_id     = ram_rdata[WORD_W-1 -: ID_BITS];
    assign slot_v    = valid_reg[eval_idx_reg];
    assign store_full = count_reg >= CNT_W'(CAPACITY);
    assign out_free  = !out_valid_reg || out_ch.ready;

    // Shared comparator: operands depend on the step in progress.
    always_comb
    begin
        if (state_reg == ST_APPLY)
        begin
            cmp_a = op_score_reg;
            cmp_b = victim_score_reg;
        end
        else if (pass_victim_reg)
        begin
            cmp_a = best_score_reg;
            cmp_b = rd_score;
        end
        else if (op_func_reg == FUNC_QUERY)
        begin
            cmp_a = rd_score;
            cmp_b = op_score_reg;
        end
        else
        begin
            cmp_a = rd_score;
            cmp_b = best_score_reg;
        end
    end

    assign cmp_gt = cmp_a > cmp_b;

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        rd_live_next      = rd_live_reg;
        pass_victim_next  = pass_victim_reg;
        found_next        = found_reg;
        valid_next        = valid_reg;
        count_next        = count_reg;
        victim_idx_next   = victim_idx_reg;
        victim_score_next = victim_score_reg;
        out_valid_next    = out_valid_reg;
        eval_idx_next     = eval_idx_reg;
        best_idx_next     = best_idx_reg;
        best_valid_next   = best_valid_reg;
        best_score_next   = best_score_reg;
        best_id_next      = best_id_reg;
        op_func_next      = op_func_reg;
        op_id_next        = op_id_reg;
        op_score_next     = op_score_reg;
        res_status_next   = res_status_reg;
        res_id_next       = res_id_reg;
        res_score_next    = res_score_reg;
        res_top_next      = res_top_reg;
        out_status_next   = out_status_reg;
        out_id_next       = out_id_reg;
        out_score_next    = out_score_reg;
        out_top_next      = out_top_reg;
        out_total_next    = out_total_reg;
        ram_we            = 1'b0;

        // The downstream side takes the held result.
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    op_func_next     = func_t'(in_ch.func);
                    op_id_next       = in_ch.item_id;
                    op_score_next    = in_ch.score;
                    scan_idx_next    = '0;
                    rd_live_next     = 1'b0;
                    found_next       = 1'b0;
                    pass_victim_next = 1'b0;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Evaluate the slot whose data arrived this cycle.
                if (rd_live_reg)
                begin
                    if (pass_victim_reg)
                    begin
                        if ((eval_idx_reg == '0) || (best_valid_reg && !slot_v)
                            || (slot_v && best_valid_reg && cmp_gt))
                        begin
                            best_idx_next   = eval_idx_reg;
                            best_valid_next = slot_v;
                            best_score_next = rd_score;
                        end
                    end
                    else
                    begin
                        unique case (op_func_reg)
                            FUNC_OFFER, FUNC_DELETE:
                            begin
                                if (slot_v && (rd_id == op_id_reg) && !found_reg)
                                begin
                                    found_next    = 1'b1;
                                    best_idx_next = eval_idx_reg;
                                end
                            end
                            FUNC_PEEK, FUNC_POP:
                            begin
                                if (slot_v && (!found_reg || cmp_gt))
                                begin
                                    found_next      = 1'b1;
                                    best_idx_next   = eval_idx_reg;
                                    best_score_next = rd_score;
                                    best_id_next    = rd_id;
                                end
                            end
                            FUNC_QUERY:
                            begin
                                if (slot_v && cmp_gt)
                                begin
                                    found_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                found_next = found_reg;
                            end
                        endcase
                    end
                end

                // Issue the next read, or close the scan.
                if (scan_more)
                begin
                    eval_idx_next = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + SCAN_W'(1);
                    rd_live_next  = 1'b1;
                end
                else
                begin
                    rd_live_next = 1'b0;
                    if (pass_victim_reg)
                    begin
                        victim_idx_next   = best_idx_next;
                        victim_score_next = best_valid_next ? best_score_next : SCORE_MIN;
                        state_next        = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end

            ST_APPLY:
            begin
                res_id_next    = '0;
                res_score_next = '0;
                res_top_next   = 1'b0;
                state_next     = ST_FINISH;
                unique case (op_func_reg)
                    FUNC_OFFER:
                    begin
                        if (store_full && !cmp_gt)
                        begin
                            res_status_next = STAT_REJECTED;
                        end
                        else if (found_reg)
                        begin
                            res_status_next = STAT_DUPLICATE;
                        end
                        else
                        begin
                            // Write the victim slot, then find the new lowest slot.
                            ram_we = 1'b1;
                            if (!store_full)
                            begin
                                valid_next[victim_idx_reg] = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = STAT_INSERTED;
                            end
                            else
                            begin
                                res_status_next = STAT_REPLACED;
                            end
                            scan_idx_next    = '0;
                            rd_live_next     = 1'b0;
                            pass_victim_next = 1'b1;
                            state_next       = ST_SCAN;
                        end
                    end
                    FUNC_PEEK, FUNC_POP:
                    begin
                        if (!found_reg)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            res_status_next = STAT_RETURNED;
                            res_id_next     = best_id_reg;
                            res_score_next  = best_score_reg;
                            if (op_func_reg == FUNC_POP)
                            begin
                                valid_next[best_idx_reg] = 1'b0;
                                victim_idx_next   = best_idx_reg;
                                victim_score_next = SCORE_MIN;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (found_reg)
                        begin
                            res_status_next = STAT_DELETED;
                            valid_next[best_idx_reg] = 1'b0;
                            victim_idx_next   = best_idx_reg;
                            victim_score_next = SCORE_MIN;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        else
                        begin
                            res_status_next = STAT_ABSENT;
                        end
                    end
                    FUNC_QUERY:
                    begin
                        res_status_next = STAT_ANSWERED;
                        res_top_next    = !found_reg;
                    end
                    default:
                    begin
                        res_status_next = STAT_REJECTED;
                    end
                endcase
            end

            ST_FINISH:
            begin
                // Move the result into the output register once it is free.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_score_next  = res_score_reg;
                    out_top_next    = res_top_reg;
                    out_total_next  = TOTAL_W'(count_reg);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_idx_reg     <= '0;
            rd_live_reg      <= 1'b0;
            pass_victim_reg  <= 1'b0;
            found_reg        <= 1'b0;
            valid_reg        <= '0;
            count_reg        <= '0;
            victim_idx_reg   <= '0;
            victim_score_reg <= SCORE_MIN;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_idx_reg     <= scan_idx_next;
            rd_live_reg      <= rd_live_next;
            pass_victim_reg  <= pass_victim_next;
            found_reg        <= found_next;
            valid_reg        <= valid_next;
            count_reg        <= count_next;
            victim_idx_reg   <= victim_idx_next;
            victim_score_reg <= victim_score_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        eval_idx_reg   <= eval_idx_next;
        best_idx_reg   <= best_idx_next;
        best_valid_reg <= best_valid_next;
        best_score_reg <= best_score_next;
        best_id_reg    <= best_id_next;
        op_func_reg    <= op_func_next;
        op_id_reg      <= op_id_next;
        op_score_reg   <= op_score_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_score_reg  <= res_score_next;
        res_top_reg    <= res_top_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_score_reg  <= out_score_next;
        out_top_reg    <= out_top_next;
        out_total_reg  <= out_total_next;
    end

    // Channel outputs.
    assign in_ch.ready        = state_reg == ST_IDLE;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.out_id      = out_id_reg;
    assign out_ch.out_score   = out_score_reg;
    assign out_ch.is_top      = out_top_reg;
    assign out_ch.entry_total = out_total_reg;

endmodule
